// ===== src/mm2_pkg.sv =====
// Shared constants for the streaming MurmurHash2 block.
`default_nettype none
package mm2_pkg;
   // Width of the hash and of one mixed word.
   localparam int unsigned HashWidth = 32;
   // Width of one key byte.
   localparam int unsigned ByteWidth = 8;
   // Width of the gathered partial word (three bytes).
   localparam int unsigned PendWidth = 24;
   // Width of the gathered byte count.
   localparam int unsigned PhaseWidth = 2;

   // Mixing multiplier and shift amounts of the hash.
   localparam logic [HashWidth-1:0] MixMul = 32'h5bd1e995;
   localparam int unsigned WordShr = 24;
   localparam int unsigned FinShrA = 13;
   localparam int unsigned FinShrB = 15;

   // Gathered byte count that completes a word on the next byte.
   localparam logic [PhaseWidth-1:0] PhaseFull = 2'd3;
   localparam logic [PhaseWidth-1:0] PhaseNone = 2'd0;
endpackage : mm2_pkg
`default_nettype wire

// ===== src/murmur2_hash_stream.sv =====
// Top level of the streaming 32-bit MurmurHash2 engine.
// A key arrives one byte per word on the req_ channel, the first word carrying
// the key length as seed and the last word closing the key; one hash comes
// out on the rsp_ channel per closed key. All multiplies go through a single
// 32x32 multiplier whose product is registered, driven by a small sequencer.
// A byte that does not complete a 4-byte group is taken while idle. A byte that
// completes a group runs three multiplies in ST_MIX_K1, ST_MIX_K2 and ST_MIX_H.
// Closing a key runs ST_FIN_A and ST_FIN_B, after ST_FIN_TAIL when 1 to 3 tail bytes
// remain, and ST_FIN_B holds while a previous hash still sits stalled on rsp_.
// The block holds req_stall high while it works on a word.
`default_nettype none
module murmur2_hash_stream (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [31:0] req_key_length,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic        req_empty_key,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_hash_value
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX_K1,
      ST_MIX_K2,
      ST_MIX_H,
      ST_FIN_TAIL,
      ST_FIN_A,
      ST_FIN_B
   } state_type;

   state_type                              state_ff;
   logic [mm2_pkg::HashWidth-1:0]          hash_ff;
   logic [mm2_pkg::HashWidth-1:0]          word_ff;
   logic [mm2_pkg::PendWidth-1:0]          pend_ff;
   logic [mm2_pkg::PhaseWidth-1:0]         phase_ff;
   logic                                   last_ff;
   logic                                   rsp_valid_ff;
   logic [mm2_pkg::HashWidth-1:0]          rsp_hash_ff;

   logic                                   req_accept;
   logic                                   rsp_free;
   logic [mm2_pkg::HashWidth-1:0]          seed_hash;
   logic [mm2_pkg::PendWidth-1:0]          seed_pend;
   logic [mm2_pkg::PhaseWidth-1:0]         seed_phase;
   logic [mm2_pkg::PendWidth-1:0]          pend_in;
   logic [mm2_pkg::PhaseWidth-1:0]         phase_in;
   logic                                   word_done;
   logic [mm2_pkg::HashWidth-1:0]          mul_op;
   logic [mm2_pkg::HashWidth-1:0]          mul_prod;

   assign req_accept     = req_valid && !req_stall;
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_free       = !(rsp_valid_ff && rsp_stall);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // A first word restarts the state; an empty key seeds with zero.
   always_comb begin
      if (req_first_byte) begin
         seed_hash  = req_empty_key ? '0 : req_key_length;
         seed_pend  = '0;
         seed_phase = mm2_pkg::PhaseNone;
      end else begin
         seed_hash  = hash_ff;
         seed_pend  = pend_ff;
         seed_phase = phase_ff;
      end
   end

   // Gather the byte little-endian; the fourth byte completes a word.
   always_comb begin
      word_done = !req_empty_key && (seed_phase == mm2_pkg::PhaseFull);
      pend_in   = seed_pend;
      phase_in  = seed_phase;
      if (!req_empty_key) begin
         phase_in = seed_phase + 2'd1;
         case (seed_phase)
            2'd0:    pend_in = {seed_pend[23:8], req_data_byte};
            2'd1:    pend_in = {seed_pend[23:16], req_data_byte, seed_pend[7:0]};
            2'd2:    pend_in = {req_data_byte, seed_pend[15:0]};
            default: pend_in = '0;
         endcase
      end
   end

   // Operand select for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_MIX_K1:   mul_op = word_ff;
         ST_MIX_K2:   mul_op = word_ff ^ (word_ff >> mm2_pkg::WordShr);
         ST_MIX_H:    mul_op = hash_ff;
         ST_FIN_TAIL: mul_op = hash_ff ^ {8'd0, pend_ff};
         ST_FIN_A:    mul_op = hash_ff ^ (hash_ff >> mm2_pkg::FinShrA);
         default:     mul_op = hash_ff;
      endcase
   end

   assign mul_prod = mul_op * mm2_pkg::MixMul;

   // Sequencer with hash state and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= '0;
         pend_ff      <= '0;
         phase_ff     <= mm2_pkg::PhaseNone;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN_B)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  hash_ff <= seed_hash;
                  last_ff <= req_last_byte;
                  if (word_done) begin
                     word_ff  <= {req_data_byte, seed_pend};
                     pend_ff  <= '0;
                     phase_ff <= mm2_pkg::PhaseNone;
                     state_ff <= ST_MIX_K1;
                  end else begin
                     pend_ff  <= pend_in;
                     phase_ff <= phase_in;
                     if (req_last_byte) begin
                        state_ff <= (phase_in != mm2_pkg::PhaseNone) ? ST_FIN_TAIL
                                                                      : ST_FIN_A;
                     end
                  end
               end
            end
            ST_MIX_K1: begin
               word_ff  <= mul_prod;
               state_ff <= ST_MIX_K2;
            end
            ST_MIX_K2: begin
               word_ff  <= mul_prod;
               state_ff <= ST_MIX_H;
            end
            ST_MIX_H: begin
               hash_ff  <= mul_prod ^ word_ff;
               state_ff <= last_ff ? ST_FIN_A : ST_IDLE;
            end
            ST_FIN_TAIL: begin
               hash_ff  <= mul_prod;
               state_ff <= ST_FIN_A;
            end
            ST_FIN_A: begin
               hash_ff  <= mul_prod;
               state_ff <= ST_FIN_B;
            end
            ST_FIN_B: begin
               // Wait here while an older hash is still held on the output.
               if (rsp_free) begin
                  rsp_hash_ff  <= hash_ff ^ (hash_ff >> mm2_pkg::FinShrB);
                  rsp_valid_ff <= 1'b1;
                  hash_ff      <= '0;
                  pend_ff      <= '0;
                  phase_ff     <= mm2_pkg::PhaseNone;
                  last_ff      <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A new hash appears only at the end of finalization.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN_B)
      else $error("hash presented outside finalization");

   // Finalization with a free output always presents the hash.
   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_B) && rsp_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finalization did not emit a hash");

   // Closing a key always starts the sequencer.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> (state_ff != ST_IDLE))
      else $error("last byte accepted without finalization");

   // A mixed word that does not close the key leaves no gathered bytes.
   a_mix_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX_H) && !last_ff |=>
         (state_ff == ST_IDLE) && (phase_ff == mm2_pkg::PhaseNone))
      else $error("word mix left stale byte count");

endmodule : murmur2_hash_stream
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming MurmurHash2 engine.
`timescale 1ns / 100ps
module tb_top;
   import mm2_pkg::*;

   // One input word plus a flag that holds it back until all hashes are out.
   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic [HashWidth-1:0] key_length;
      logic                 first_byte;
      logic                 last_byte;
      logic                 empty_key;
      logic                 drain_first;
   } key_word_t;

   typedef enum int {
      StallNever,
      StallLight,
      StallHeavy,
      StallPeriodic
   } stall_mode_e;

   localparam int ItemTarget  = 1150;
   localparam int CycleLimit  = 500000;
   localparam int TailCycles  = 16;
   localparam int DrainEvery  = 150;
   localparam int ReportLimit = 10;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   key_word_t            drive_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [HashWidth-1:0] rsp_hash_value;

   // Words waiting to be sent and hashes waiting to come back.
   key_word_t            pending_words[$];
   logic [HashWidth-1:0] expected_hashes[$];

   // Running hash state of the predictor.
   logic [HashWidth-1:0] run_hash = '0;
   logic [PendWidth-1:0] gathered = '0;
   logic [PhaseWidth-1:0] gathered_count = PhaseNone;

   int          words_taken = 0;
   int          hashes_due = 0;
   int          hashes_seen = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          total_words = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   logic        word_fired;
   logic        settled;
   logic        drain_armed = 1'b0;
   stall_mode_e stall_mode = StallNever;
   int          mode_left = 0;

   murmur2_hash_stream dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (drive_word.data_byte),
      .req_key_length (drive_word.key_length),
      .req_first_byte (drive_word.first_byte),
      .req_last_byte  (drive_word.last_byte),
      .req_empty_key  (drive_word.empty_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Fold one accepted word into the hash; a closing word yields the expected hash.
   task automatic fold_key_byte(input key_word_t w);
      logic [HashWidth-1:0] k;
      logic [HashWidth-1:0] h;
      if (w.first_byte) begin
         run_hash = w.empty_key ? '0 : w.key_length;
         gathered = '0;
         gathered_count = PhaseNone;
      end
      if (!w.empty_key) begin
         if (gathered_count == PhaseFull) begin
            k = {w.data_byte, gathered};
            k = k * MixMul;
            k = k ^ (k >> WordShr);
            k = k * MixMul;
            run_hash = (run_hash * MixMul) ^ k;
            gathered = '0;
            gathered_count = PhaseNone;
         end else begin
            gathered[ByteWidth*gathered_count +: ByteWidth] = w.data_byte;
            gathered_count = gathered_count + 1'b1;
         end
      end
      if (w.last_byte) begin
         h = run_hash;
         // A partial word left at the end is folded in as the tail.
         if (gathered_count != PhaseNone) begin
            h = h ^ {{(HashWidth-PendWidth){1'b0}}, gathered};
            h = h * MixMul;
         end
         h = h ^ (h >> FinShrA);
         h = h * MixMul;
         h = h ^ (h >> FinShrB);
         expected_hashes.push_back(h);
         run_hash = '0;
         gathered = '0;
         gathered_count = PhaseNone;
      end
   endtask

   task automatic push_word(input logic [7:0] data, input logic [31:0] len,
                            input logic first, input logic last, input logic empty);
      key_word_t w;
      w.data_byte = data;
      w.key_length = len;
      w.first_byte = first;
      w.last_byte = last;
      w.empty_key = empty;
      w.drain_first = drain_armed;
      drain_armed = 1'b0;
      pending_words.push_back(w);
   endtask

   task automatic note_miss(input string what, input logic [31:0] want,
                            input logic [31:0] got);
      if (mismatch_count < ReportLimit)
         $display("hash mismatch (%s) at cycle %0d: expected %08h, got %08h",
                  what, cycle_count, want, got);
      mismatch_count++;
   endtask

   // Sender: bursts of words with random gaps, holding a stalled word steady.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         word_fired = req_valid && !req_stall;
         if (word_fired) begin
            fold_key_byte(drive_word);
            words_taken <= words_taken + 1;
            if (drive_word.last_byte) hashes_due <= hashes_due + 1;
         end
         if (!req_valid || word_fired) begin
            settled = (hashes_due == hashes_seen) && !(word_fired && drive_word.last_byte);
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0 ||
                         (pending_words[0].drain_first && !settled)) begin
               req_valid <= 1'b0;
            end else begin
               drive_word <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                            : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Receiver: checks each hash and stalls on a pattern that changes mode.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            hashes_seen <= hashes_seen + 1;
            if (expected_hashes.size() == 0)
               note_miss("no hash expected", '0, rsp_hash_value);
            else if (rsp_hash_value !== expected_hashes[0])
               note_miss("hash_value", expected_hashes.pop_front(), rsp_hash_value);
            else
               void'(expected_hashes.pop_front());
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 300);
         end
         mode_left--;
         case (stall_mode)
            StallNever: begin
               rsp_stall <= 1'b0;
            end
            StallLight: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            StallHeavy: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= ((cycle_count % 7) < 3);
            end
         endcase
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // Stimulus: directed keys, then random keys with some noise, then the final check.
   initial begin
      int n;
      int keys_made;
      logic [31:0] seed;

      // Bytes right after reset carry on from a zero seed.
      push_word(8'h55, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
      push_word(8'h66, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
      // Empty key hashes to zero whatever the length field says.
      push_word(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
      // Single-byte key.
      push_word(8'hff, 32'h0000_0001, 1'b1, 1'b1, 1'b0);
      // Exactly one full word, no tail.
      push_word(8'h00, 32'h0000_0004, 1'b1, 1'b0, 1'b0);
      push_word(8'hff, 32'h0000_0004, 1'b0, 1'b0, 1'b0);
      push_word(8'h80, 32'h0000_0004, 1'b0, 1'b0, 1'b0);
      push_word(8'h7f, 32'h0000_0004, 1'b0, 1'b1, 1'b0);
      // Five bytes under a length field that disagrees.
      push_word(8'hff, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
      repeat (3) push_word(8'hff, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
      push_word(8'hff, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
      // An empty opening word seeds zero, then bytes follow.
      push_word(8'h3c, 32'hffff_ffff, 1'b1, 1'b0, 1'b1);
      push_word(8'ha5, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
      push_word(8'h5a, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
      // Empty words inside a key gather nothing; an empty closing word ends it.
      push_word(8'h12, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
      push_word(8'hab, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
      push_word(8'h34, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
      push_word(8'hcd, 32'h0000_0000, 1'b0, 1'b1, 1'b1);
      // A new opening word abandons a key midway.
      push_word(8'h01, 32'h0000_0009, 1'b1, 1'b0, 1'b0);
      push_word(8'h02, 32'h0000_0001, 1'b1, 1'b1, 1'b0);

      keys_made = 0;
      while (pending_words.size() < ItemTarget) begin
         if (keys_made % DrainEvery == 0) drain_armed = 1'b1;
         keys_made++;
         if ($urandom_range(0, 9) == 0) begin
            // Noise: any combination of flags and fields.
            push_word(8'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            seed = ($urandom_range(0, 4) == 0) ? $urandom : n;
            if (n == 0) begin
               push_word(8'($urandom_range(0, 255)), seed, 1'b1, 1'b1, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  if (i != 0 && $urandom_range(0, 11) == 0)
                     push_word(8'($urandom_range(0, 255)), $urandom, 1'b0, 1'b0, 1'b1);
                  push_word(8'($urandom_range(0, 255)), seed, i == 0, i == n - 1, 1'b0);
               end
            end
         end
      end
      total_words = pending_words.size();

      while (words_taken != total_words) @(posedge clock);
      while (hashes_seen != hashes_due) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_hashes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
